// ===== src/iae_pkg.sv =====
// ----------------------------------------------------------------------------
// iae_pkg: shared types and codes for the bounded indexed array
// Request, response and internal command formats, request kinds and status
// codes used by the front end, the command queue and the execution back end.
// ----------------------------------------------------------------------------
package iae_pkg;

  // Request kinds.
  localparam logic [2:0] KIND_READ        = 3'd0;
  localparam logic [2:0] KIND_WRITE       = 3'd1;
  localparam logic [2:0] KIND_APPEND      = 3'd2;
  localparam logic [2:0] KIND_REMOVE_LAST = 3'd3;
  localparam logic [2:0] KIND_INSERT      = 3'd4;
  localparam logic [2:0] KIND_ERASE       = 3'd5;
  localparam logic [2:0] KIND_CLEAR       = 3'd6;
  localparam logic [2:0] KIND_RESIZE      = 3'd7;

  // Result status codes.
  localparam logic [2:0] STAT_OK        = 3'd0;
  localparam logic [2:0] STAT_BAD_INDEX = 3'd1;
  localparam logic [2:0] STAT_FULL      = 3'd2;
  localparam logic [2:0] STAT_EMPTY     = 3'd3;
  localparam logic [2:0] STAT_TOO_LARGE = 3'd4;

  typedef struct packed {
    logic [2:0]  kind;
    logic [5:0]  index;
    logic [63:0] value;
    logic [6:0]  new_length;
  } iae_req_t;

  typedef struct packed {
    logic [63:0] read_value;
    logic [6:0]  length;
    logic [2:0]  status;
  } iae_resp_t;

  // A classified request as it sits in the command queue.
  typedef struct packed {
    logic [2:0]  kind;
    logic        chk_lt;     // index must be below the length
    logic        chk_le;     // index must not exceed the length
    logic        need_room;  // request adds an entry
    logic        need_item;  // request removes the last entry
    logic        size_bad;   // requested length exceeds the capacity
    logic [5:0]  index;
    logic [63:0] value;
    logic [6:0]  new_length;
  } iae_cmd_t;

endpackage

// ===== src/iae_front.sv =====
// ----------------------------------------------------------------------------
// iae_front: request classifier
// Accepts requests while the command queue has room and turns each one into
// a command carrying the checks that the back end must apply.
// ----------------------------------------------------------------------------
module iae_front #(
  parameter int CAPACITY = 64
) (
  input  logic              in_valid,
  output logic              in_stall,
  input  iae_pkg::iae_req_t in_req,
  input  logic              q_full,
  output logic              push,
  output iae_pkg::iae_cmd_t push_cmd
);
  import iae_pkg::*;

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    push_cmd            = '0;
    push_cmd.kind       = in_req.kind;
    push_cmd.index      = in_req.index;
    push_cmd.value      = in_req.value;
    push_cmd.new_length = in_req.new_length;
    unique case (in_req.kind) inside
      KIND_READ, KIND_WRITE, KIND_ERASE: begin
        push_cmd.chk_lt = 1'b1;
      end
      KIND_APPEND: begin
        push_cmd.need_room = 1'b1;
      end
      KIND_INSERT: begin
        push_cmd.chk_le    = 1'b1;
        push_cmd.need_room = 1'b1;
      end
      KIND_REMOVE_LAST: begin
        push_cmd.need_item = 1'b1;
      end
      KIND_RESIZE: begin
        push_cmd.size_bad = 32'(in_req.new_length) > 32'(CAPACITY);
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== src/iae_queue.sv =====
// ----------------------------------------------------------------------------
// iae_queue: two-entry command queue
// Decouples the request classifier from the execution back end.
// ----------------------------------------------------------------------------
module iae_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  iae_pkg::iae_cmd_t push_cmd,
  output logic              full,
  input  logic              pop,
  output logic              head_valid,
  output iae_pkg::iae_cmd_t head
);
  import iae_pkg::*;

  iae_cmd_t   slot_r [2];
  logic [1:0] fill_r, fill_nxt;
  logic       wr_ptr_r, rd_ptr_r;

  assign full       = fill_r == 2'd2;
  assign head_valid = fill_r != 2'd0;
  assign head       = slot_r[rd_ptr_r];

  always_comb begin
    fill_nxt = fill_r;
    if (push && !pop) begin
      fill_nxt = fill_r + 2'd1;
    end else if (pop && !push) begin
      fill_nxt = fill_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r   <= 2'd0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      fill_r <= fill_nxt;
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ===== src/iae_back.sv =====
// ----------------------------------------------------------------------------
// iae_back: execution back end
// Holds the word store and the length, checks each command, carries it out
// through a sequencer over the store memory and registers the response.
// ----------------------------------------------------------------------------
module iae_back #(
  parameter int CAPACITY = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               head_valid,
  input  iae_pkg::iae_cmd_t  head,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output iae_pkg::iae_resp_t out_resp
);
  import iae_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int W  = (CW > 7) ? CW : 7;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RDATA = 3'd1;
  localparam logic [2:0] S_SHIFT = 3'd2;
  localparam logic [2:0] S_PUT   = 3'd3;
  localparam logic [2:0] S_ZERO  = 3'd4;

  logic [63:0]   store_r [CAPACITY];
  logic [63:0]   rdata_r;

  logic [2:0]    state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [AW-1:0] ptr_r, ptr_nxt;
  iae_cmd_t      cmd_r;
  logic          out_valid_r, out_valid_nxt;
  iae_resp_t     out_resp_r, out_resp_nxt;

  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [63:0]   mem_wdata;

  logic          res_set;
  logic [63:0]   res_rd;
  logic [2:0]    res_status;

  logic [W-1:0]  count_w, idx_w, want_w, cap_w, cnt_nxt_w;
  logic          out_free, bad_idx, is_full, is_empty;

  assign count_w  = W'(count_r);
  assign idx_w    = W'(head.index);
  assign want_w   = W'(head.new_length);
  assign cap_w    = W'(CAPACITY);
  assign out_free = !out_valid_r || !out_stall;

  assign bad_idx  = (head.chk_lt && idx_w >= count_w) || (head.chk_le && idx_w > count_w);
  assign is_full  = head.need_room && count_w == cap_w;
  assign is_empty = head.need_item && count_w == '0;

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    ptr_nxt    = ptr_r;
    pop        = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = ptr_r;
    mem_wdata  = '0;
    mem_re     = 1'b0;
    mem_raddr  = ptr_r;
    res_set    = 1'b0;
    res_rd     = '0;
    res_status = STAT_OK;
    unique case (state_r)
      S_IDLE: begin
        if (head_valid && out_free) begin
          pop = 1'b1;
          if (bad_idx) begin
            res_set    = 1'b1;
            res_status = STAT_BAD_INDEX;
          end else if (is_full) begin
            res_set    = 1'b1;
            res_status = STAT_FULL;
          end else if (is_empty) begin
            res_set    = 1'b1;
            res_status = STAT_EMPTY;
          end else if (head.size_bad) begin
            res_set    = 1'b1;
            res_status = STAT_TOO_LARGE;
          end else begin
            unique case (head.kind)
              KIND_READ: begin
                mem_re    = 1'b1;
                mem_raddr = AW'(head.index);
                state_nxt = S_RDATA;
              end
              KIND_WRITE: begin
                mem_we    = 1'b1;
                mem_waddr = AW'(head.index);
                mem_wdata = head.value;
                res_set   = 1'b1;
              end
              KIND_APPEND: begin
                mem_we    = 1'b1;
                mem_waddr = AW'(count_r);
                mem_wdata = head.value;
                count_nxt = count_r + CW'(1);
                res_set   = 1'b1;
              end
              KIND_REMOVE_LAST: begin
                count_nxt = count_r - CW'(1);
                res_set   = 1'b1;
              end
              KIND_INSERT: begin
                if (idx_w == count_w) begin
                  // Insert at the end is an append.
                  mem_we    = 1'b1;
                  mem_waddr = AW'(count_r);
                  mem_wdata = head.value;
                  count_nxt = count_r + CW'(1);
                  res_set   = 1'b1;
                end else begin
                  ptr_nxt   = AW'(count_r);
                  mem_re    = 1'b1;
                  mem_raddr = AW'(count_r - CW'(1));
                  state_nxt = S_SHIFT;
                end
              end
              KIND_ERASE: begin
                if (idx_w == count_w - W'(1)) begin
                  count_nxt = count_r - CW'(1);
                  res_set   = 1'b1;
                end else begin
                  ptr_nxt   = AW'(head.index);
                  mem_re    = 1'b1;
                  mem_raddr = AW'(head.index) + AW'(1);
                  state_nxt = S_SHIFT;
                end
              end
              KIND_CLEAR: begin
                count_nxt = '0;
                res_set   = 1'b1;
              end
              default: begin
                // Resize: slots above the length hold stale data, so growth
                // zeroes the newly exposed slots first.
                if (want_w <= count_w) begin
                  count_nxt = CW'(want_w);
                  res_set   = 1'b1;
                end else begin
                  ptr_nxt   = AW'(count_r);
                  state_nxt = S_ZERO;
                end
              end
            endcase
          end
        end
      end
      S_RDATA: begin
        res_rd    = rdata_r;
        res_set   = 1'b1;
        state_nxt = S_IDLE;
      end
      S_SHIFT: begin
        mem_we    = 1'b1;
        mem_waddr = ptr_r;
        mem_wdata = rdata_r;
        if (cmd_r.kind == KIND_INSERT) begin
          if (ptr_r - AW'(1) == AW'(cmd_r.index)) begin
            state_nxt = S_PUT;
          end else begin
            ptr_nxt   = ptr_r - AW'(1);
            mem_re    = 1'b1;
            mem_raddr = ptr_r - AW'(2);
          end
        end else begin
          if (CW'(ptr_r) + CW'(1) == count_r - CW'(1)) begin
            count_nxt = count_r - CW'(1);
            res_set   = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            ptr_nxt   = ptr_r + AW'(1);
            mem_re    = 1'b1;
            mem_raddr = ptr_r + AW'(2);
          end
        end
      end
      S_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(cmd_r.index);
        mem_wdata = cmd_r.value;
        count_nxt = count_r + CW'(1);
        res_set   = 1'b1;
        state_nxt = S_IDLE;
      end
      S_ZERO: begin
        mem_we    = 1'b1;
        mem_waddr = ptr_r;
        mem_wdata = '0;
        if (CW'(ptr_r) + CW'(1) == CW'(cmd_r.new_length)) begin
          count_nxt = CW'(cmd_r.new_length);
          res_set   = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          ptr_nxt = ptr_r + AW'(1);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign cnt_nxt_w = W'(count_nxt);

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    out_resp_nxt  = out_resp_r;
    if (res_set) begin
      out_valid_nxt           = 1'b1;
      out_resp_nxt.read_value = res_rd;
      out_resp_nxt.length     = cnt_nxt_w[6:0];
      out_resp_nxt.status     = res_status;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r      <= ptr_nxt;
    out_resp_r <= out_resp_nxt;
    if (pop) begin
      cmd_r <= head;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      store_r[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_r <= store_r[mem_raddr];
    end
  end

  assign out_valid = out_valid_r;
  assign out_resp  = out_resp_r;

endmodule

// ===== src/indexed_array_insert_erase_top.sv =====
// ----------------------------------------------------------------------------
// indexed_array_insert_erase_top: bounded ordered array of 64-bit words
// Read, write, append, remove last, insert, erase, clear and resize on an
// array of up to CAPACITY words, one response per request.
// ----------------------------------------------------------------------------
// The block keeps up to CAPACITY words in positions 0 to length-1 in a single
// memory with one write port and one registered read port. Requests enter a
// classifier and a two-entry queue, so new requests are taken while the back
// end is busy or a response waits on out_stall. The back end works on one
// request at a time. Failed requests, writes, appends, remove last, clear,
// shrinking resizes and inserts or erases at the last position finish in
// the idle state. A successful read also passes through S_RDATA because of
// the registered memory read. An insert at index i below the length n
// shifts the words from i up in S_SHIFT and writes the new word in S_PUT;
// an erase at index i below n - 1 shifts the words above i down in S_SHIFT.
// The shift moves one word per cycle through the memory read and write
// ports. A resize that grows the length from n to m zeroes the exposed
// slots one per cycle in S_ZERO. A request is written into the queue at the
// edge that accepts it and waits until the back end pops it; one that needs
// no sequencing registers its response as it is popped. No clearing pass is
// needed after reset: slots at or above the length are never read as data
// and are written before any request exposes them.
module indexed_array_insert_erase_top #(
  parameter int CAPACITY = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  iae_pkg::iae_req_t  in_req,
  output logic               out_valid,
  input  logic               out_stall,
  output iae_pkg::iae_resp_t out_resp
);
  import iae_pkg::*;

  // Front end to queue.
  logic     push;
  logic     q_full;
  iae_cmd_t push_cmd;

  // Queue to back end.
  logic     head_valid;
  logic     pop;
  iae_cmd_t head;

  // The front end classifies each request by the checks it needs; the checks
  // against the current length are made in the back end, which owns it.
  iae_front #(
    .CAPACITY (CAPACITY)
  ) u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_req   (in_req),
    .q_full   (q_full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  iae_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  // The back end pops a command only when the response register is free or
  // being emptied, so every multi-cycle sequence finishes into a free slot.
  iae_back #(
    .CAPACITY (CAPACITY)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_resp   (out_resp)
  );

endmodule

// ===== src/iae_checker.sv =====
// ----------------------------------------------------------------------------
// iae_checker: port-level checks for the bounded indexed array
// Watches the top-level ports and flags responses that cannot be right.
// ----------------------------------------------------------------------------
module iae_checker #(
  parameter int CAPACITY = 64
) (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input iae_pkg::iae_req_t  in_req,
  input logic               out_valid,
  input logic               out_stall,
  input iae_pkg::iae_resp_t out_resp
);
  import iae_pkg::*;

  // A stalled request holds until it is taken.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_req))
    else $error("stalled request changed");

  // A stalled response holds until it is taken.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_resp))
    else $error("stalled response changed");

  // A failed request never returns data.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_resp.status != STAT_OK |-> out_resp.read_value == '0)
    else $error("failed request returned data");

  // The reported length never exceeds the capacity.
  a_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (CAPACITY >= 128) || (32'(out_resp.length) <= 32'(CAPACITY)))
    else $error("length above capacity");

  // Reset leaves no response pending.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("response valid after reset");

endmodule

bind indexed_array_insert_erase_top iae_checker #(.CAPACITY(CAPACITY)) u_iae_checker (.*);
